/* rtl/smsa_pkg.sv */
// Shared types and constants for the size-matched slot allocator.
// No dependencies.
`default_nettype none

package smsa_pkg;

   localparam int SLOTS_DEF = 256;
   localparam int MAX_VERTICES_DEF = 1023;
   localparam int VC_W = 10;
   localparam int STATUS_W = 2;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_SEED,
      OP_STEP,
      OP_REMOVE,
      OP_APPEND
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [VC_W-1:0]   size;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_ALLOC,
      FSM_FREE
   } fsm_type;

endpackage

`default_nettype wire

/* rtl/smsa_cell.sv */
// One free-list cell: holds a freed slot and its size, plus a prefix-match register.
// Depends on smsa_pkg.
`default_nettype none

module smsa_cell #(
   parameter int SLOT_W = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  smsa_pkg::cell_ctl_type     ctl,
   input  logic                       app_sel,
   input  logic [SLOT_W-1:0]          app_id,
   input  logic                       nxt_val,
   input  logic [SLOT_W-1:0]          nxt_id,
   input  logic [smsa_pkg::VC_W-1:0]  nxt_size,
   input  logic                       src_found,
   input  logic [SLOT_W-1:0]          src_id,
   output logic                       val,
   output logic [SLOT_W-1:0]          id,
   output logic [smsa_pkg::VC_W-1:0]  size,
   output logic                       pf_found,
   output logic [SLOT_W-1:0]          pf_id
);
   import smsa_pkg::*;

   logic              val_ff, val_in;
   logic [SLOT_W-1:0] id_ff, id_in;
   logic [VC_W-1:0]   size_ff, size_in;
   logic              pf_found_ff, pf_found_in;
   logic [SLOT_W-1:0] pf_id_ff, pf_id_in;

   always_comb begin
      val_in      = val_ff;
      id_in       = id_ff;
      size_in     = size_ff;
      pf_found_in = pf_found_ff;
      pf_id_in    = pf_id_ff;
      case (ctl.op)
         OP_SEED: begin
            pf_found_in = val_ff && (size_ff == ctl.size);
            pf_id_in    = id_ff;
         end
         OP_STEP: begin
            // earlier cells win
            pf_found_in = pf_found_ff | src_found;
            pf_id_in    = src_found ? src_id : pf_id_ff;
         end
         OP_REMOVE: begin
            if (pf_found_ff) begin
               val_in  = nxt_val;
               id_in   = nxt_id;
               size_in = nxt_size;
            end
         end
         OP_APPEND: begin
            if (app_sel) begin
               val_in  = 1'b1;
               id_in   = app_id;
               size_in = ctl.size;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff      <= 1'b0;
         pf_found_ff <= 1'b0;
      end else begin
         val_ff      <= val_in;
         pf_found_ff <= pf_found_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      size_ff  <= size_in;
      pf_id_ff <= pf_id_in;
   end

   assign val      = val_ff;
   assign id       = id_ff;
   assign size     = size_ff;
   assign pf_found = pf_found_ff;
   assign pf_id    = pf_id_ff;

endmodule

`default_nettype wire

/* rtl/size_matched_slot_allocator.sv */
// Size-matched slot allocator: control sequencer, slot size memory and the free-list cell row.
// Depends on smsa_pkg and smsa_cell.
`default_nettype none

// A request is taken when start is high and busy is low. Its single result
// beat appears on the rsp_ ports for one cycle, marked by rsp_valid, and the
// receiver cannot stall it. The size match flags load into the free-list
// cells at the accept edge. The SCAN state then runs the first-match prefix
// network across the cell row, level by level. The ALLOC state commits and
// registers the result, which is shown in the cycle after. An allocate above
// MAX_VERTICES is answered from the idle state with no scan. A free goes
// through the FREE state, which uses the registered read of the slot size
// memory. busy drops as the result is registered, so the next request may
// be taken while the result is shown.
module size_matched_slot_allocator #(
   parameter int SLOTS        = smsa_pkg::SLOTS_DEF,
   parameter int MAX_VERTICES = smsa_pkg::MAX_VERTICES_DEF,
   localparam int SLOT_W      = $clog2(SLOTS)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_type,
   input  logic [smsa_pkg::VC_W-1:0]      req_vertex_count,
   input  logic [SLOT_W-1:0]              req_slot_index,
   output logic                           rsp_valid,
   output logic [SLOT_W-1:0]              rsp_slot_index_out,
   output logic                           rsp_reused,
   output logic [smsa_pkg::STATUS_W-1:0]  rsp_status
);
   import smsa_pkg::*;

   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int LVLS  = $clog2(SLOTS);
   localparam int LCW   = $clog2(LVLS + 1);

   fsm_type           state_ff, state_in;
   logic [LCW-1:0]    lvl_ff, lvl_in;
   logic [CNT_W-1:0]  created_ff, created_in;
   logic [CNT_W-1:0]  length_ff, length_in;
   logic [SLOTS-1:0]  slot_free_ff;
   logic [VC_W-1:0]   vc_ff;
   logic [SLOT_W-1:0] sidx_ff;
   logic [VC_W-1:0]   size_rd_ff;
   logic [VC_W-1:0]   size_mem [SLOTS];

   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic              rsp_reused_ff, rsp_reused_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic              accept;
   logic              mem_we;
   logic              set_free, clr_free;
   logic [SLOT_W-1:0] free_idx;
   logic              free_bad;
   cell_ctl_type      ctl;

   logic              c_val      [SLOTS];
   logic [SLOT_W-1:0] c_id       [SLOTS];
   logic [VC_W-1:0]   c_size     [SLOTS];
   logic              c_pf_found [SLOTS];
   logic [SLOT_W-1:0] c_pf_id    [SLOTS];

   logic              hit_found;
   logic [SLOT_W-1:0] hit_id;

   assign busy   = (state_ff != FSM_IDLE);
   assign accept = start && !busy;

   assign hit_found = c_pf_found[SLOTS-1];
   assign hit_id    = c_pf_id[SLOTS-1];

   assign free_bad = (CNT_W'(sidx_ff) >= created_ff) || slot_free_ff[sidx_ff] ||
                     (length_ff >= CNT_W'(SLOTS));

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      logic              lf [LVLS];
      logic [SLOT_W-1:0] li [LVLS];
      logic              src_found;
      logic [SLOT_W-1:0] src_id;
      logic              nxt_val;
      logic [SLOT_W-1:0] nxt_id;
      logic [VC_W-1:0]   nxt_size;

      for (genvar l = 0; l < LVLS; l++) begin : g_lvl
         if (i >= (1 << l)) begin : g_src
            assign lf[l] = c_pf_found[i - (1 << l)] && (lvl_ff == LCW'(l));
            assign li[l] = lf[l] ? c_pf_id[i - (1 << l)] : '0;
         end else begin : g_none
            assign lf[l] = 1'b0;
            assign li[l] = '0;
         end
      end

      always_comb begin
         src_found = 1'b0;
         src_id    = '0;
         for (int l = 0; l < LVLS; l++) begin
            src_found = src_found | lf[l];
            src_id    = src_id | li[l];
         end
      end

      if (i < SLOTS - 1) begin : g_nxt
         assign nxt_val  = c_val[i+1];
         assign nxt_id   = c_id[i+1];
         assign nxt_size = c_size[i+1];
      end else begin : g_last
         assign nxt_val  = 1'b0;
         assign nxt_id   = '0;
         assign nxt_size = '0;
      end

      smsa_cell #(
         .SLOT_W (SLOT_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .app_sel   (length_ff == CNT_W'(i)),
         .app_id    (sidx_ff),
         .nxt_val   (nxt_val),
         .nxt_id    (nxt_id),
         .nxt_size  (nxt_size),
         .src_found (src_found),
         .src_id    (src_id),
         .val       (c_val[i]),
         .id        (c_id[i]),
         .size      (c_size[i]),
         .pf_found  (c_pf_found[i]),
         .pf_id     (c_pf_id[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      lvl_in        = lvl_ff;
      created_in    = created_ff;
      length_in     = length_ff;
      mem_we        = 1'b0;
      set_free      = 1'b0;
      clr_free      = 1'b0;
      free_idx      = sidx_ff;
      ctl.op        = OP_HOLD;
      ctl.size      = vc_ff;
      rsp_valid_in  = 1'b0;
      rsp_idx_in    = '0;
      rsp_reused_in = 1'b0;
      rsp_status_in = ST_OK;
      case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               if (req_type == REQ_FREE) begin
                  state_in = FSM_FREE;
               end else if (32'(req_vertex_count) > 32'(MAX_VERTICES)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_FULL;
               end else begin
                  state_in = FSM_SCAN;
                  lvl_in   = '0;
                  ctl.op   = OP_SEED;
                  ctl.size = req_vertex_count;
               end
            end
         end
         FSM_SCAN: begin
            ctl.op = OP_STEP;
            if (lvl_ff == LCW'(LVLS - 1)) begin
               state_in = FSM_ALLOC;
            end else begin
               lvl_in = lvl_ff + 1'b1;
            end
         end
         FSM_ALLOC: begin
            state_in     = FSM_IDLE;
            rsp_valid_in = 1'b1;
            if (hit_found) begin
               ctl.op        = OP_REMOVE;
               length_in     = length_ff - 1'b1;
               clr_free      = 1'b1;
               free_idx      = hit_id;
               rsp_idx_in    = hit_id;
               rsp_reused_in = 1'b1;
            end else if (created_ff < CNT_W'(SLOTS)) begin
               mem_we     = 1'b1;
               created_in = created_ff + 1'b1;
               rsp_idx_in = created_ff[SLOT_W-1:0];
            end else begin
               rsp_status_in = ST_FULL;
            end
         end
         FSM_FREE: begin
            state_in     = FSM_IDLE;
            rsp_valid_in = 1'b1;
            rsp_idx_in   = sidx_ff;
            if (free_bad) begin
               rsp_status_in = ST_BAD;
            end else begin
               ctl.op    = OP_APPEND;
               ctl.size  = size_rd_ff;
               length_in = length_ff + 1'b1;
               set_free  = 1'b1;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         lvl_ff       <= '0;
         created_ff   <= '0;
         length_ff    <= '0;
         slot_free_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lvl_ff       <= lvl_in;
         created_ff   <= created_in;
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
         if (set_free) begin
            slot_free_ff[free_idx] <= 1'b1;
         end
         if (clr_free) begin
            slot_free_ff[free_idx] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         vc_ff   <= req_vertex_count;
         sidx_ff <= req_slot_index;
      end
      rsp_idx_ff    <= rsp_idx_in;
      rsp_reused_ff <= rsp_reused_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         size_mem[created_ff[SLOT_W-1:0]] <= vc_ff;
      end
      size_rd_ff <= size_mem[req_slot_index];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_slot_index_out = rsp_idx_ff;
   assign rsp_reused         = rsp_reused_ff;
   assign rsp_status         = rsp_status_ff;

`ifndef NO_ASSERTIONS
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result beats");

   a_len_le_created: assert property (@(posedge clock) disable iff (reset)
      length_ff <= created_ff)
      else $error("free list longer than created slots");

   a_free_count: assert property (@(posedge clock) disable iff (reset)
      $countones(slot_free_ff) == int'(length_ff))
      else $error("free flags disagree with free list length");

   a_reuse_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reused) |-> (rsp_status == ST_OK))
      else $error("reused slot with failing status");

   a_free_path: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_type == REQ_FREE)) |=> (state_ff == FSM_FREE))
      else $error("free request did not enter free check");
`endif

endmodule

`default_nettype wire

/* sim/size_matched_slot_allocator_tb.sv */
// Self-checking testbench for size_matched_slot_allocator: drives allocate and free beats,
// predicts each grant with an exact-fit free-list scoreboard and checks every response.
// Depends on smsa_pkg and the size_matched_slot_allocator RTL.
`timescale 1ns / 100ps

class slot_alloc_scoreboard;
   localparam int SLOTS  = smsa_pkg::SLOTS_DEF;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int VC_W   = smsa_pkg::VC_W;

   typedef struct packed {
      logic [SLOT_W-1:0]    slot;
      logic                 reused;
      smsa_pkg::status_type status;
   } grant_type;

   int unsigned       slots_created;
   logic [VC_W-1:0]   size_of [SLOTS];
   bit                on_free_list [SLOTS];
   logic [SLOT_W-1:0] free_list [$];
   grant_type         grants_due [$];
   int                errors;

   function new();
      slots_created = 0;
      errors = 0;
      foreach (size_of[i]) begin
         size_of[i] = '0;
         on_free_list[i] = 1'b0;
      end
   endfunction

   function int pending();
      return grants_due.size();
   endfunction

   function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
   endfunction

   function void note_request(smsa_pkg::req_kind_type kind, logic [VC_W-1:0] vc,
                              logic [SLOT_W-1:0] idx);
      grant_type g;
      int        pos;
      g.slot = '0;
      g.reused = 1'b0;
      g.status = smsa_pkg::ST_FULL;
      pos = -1;
      if (kind == smsa_pkg::REQ_FREE) begin
         g.slot = idx;
         if (idx >= slots_created || on_free_list[idx]) begin
            g.status = smsa_pkg::ST_BAD;
         end else begin
            free_list = {free_list, idx};
            on_free_list[idx] = 1'b1;
            g.status = smsa_pkg::ST_OK;
         end
      end else if (vc <= smsa_pkg::MAX_VERTICES_DEF) begin
         // oldest free entry of the same size wins
         foreach (free_list[i]) begin
            if (pos < 0 && size_of[free_list[i]] == vc) pos = i;
         end
         if (pos >= 0) begin
            g.slot = free_list[pos];
            free_list.delete(pos);
            on_free_list[g.slot] = 1'b0;
            g.reused = 1'b1;
            g.status = smsa_pkg::ST_OK;
         end else if (slots_created < SLOTS) begin
            g.slot = SLOT_W'(slots_created);
            size_of[slots_created] = vc;
            slots_created++;
            g.status = smsa_pkg::ST_OK;
         end
      end
      grants_due = {grants_due, g};
   endfunction

   function void check_response(logic [SLOT_W-1:0] slot, logic reused,
                                logic [smsa_pkg::STATUS_W-1:0] status);
      grant_type want;
      if (grants_due.size() == 0) begin
         flag($sformatf("unexpected response: slot %0d reused %0d status %0d",
                        slot, reused, status));
         return;
      end
      want = grants_due[0];
      grants_due.delete(0);
      if (slot !== want.slot || reused !== want.reused || status !== want.status) begin
         flag($sformatf({"mismatch: expected slot %0d reused %0d status %0d, ",
                         "got slot %0d reused %0d status %0d"},
                        want.slot, want.reused, want.status, slot, reused, status));
      end
   endfunction

   function void close_out();
      if (grants_due.size() != 0) begin
         flag($sformatf("%0d responses never arrived", grants_due.size()));
      end
   endfunction
endclass

module size_matched_slot_allocator_tb;
   import smsa_pkg::*;

   localparam int SLOTS          = SLOTS_DEF;
   localparam int SLOT_W         = $clog2(SLOTS);
   localparam int ITEMS_PER_LOOP = 400;
   localparam int TAIL_CYCLES    = 40;
   localparam int CYCLE_LIMIT    = 400000;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_type;
   logic [VC_W-1:0]   req_vertex_count;
   logic [SLOT_W-1:0] req_slot_index;
   logic              rsp_valid;
   logic [SLOT_W-1:0] rsp_slot_index_out;
   logic              rsp_reused;
   logic [STATUS_W-1:0] rsp_status;

   slot_alloc_scoreboard sb;
   int unsigned          cycles;
   // sender idle percentage per loop; the receiver cannot stall, so the loops at 0 run back to back
   int                   idle_pct [4] = '{0, 81, 0, 20};

   size_matched_slot_allocator i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_vertex_count   (req_vertex_count),
      .req_slot_index     (req_slot_index),
      .rsp_valid          (rsp_valid),
      .rsp_slot_index_out (rsp_slot_index_out),
      .rsp_reused         (rsp_reused),
      .rsp_status         (rsp_status)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         sb.check_response(rsp_slot_index_out, rsp_reused, rsp_status);
      end
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL");
      $finish;
   end

   task automatic send_request(input req_kind_type kind, input logic [VC_W-1:0] vc,
                               input logic [SLOT_W-1:0] idx);
      @(negedge clock);
      start <= 1'b1;
      req_type <= kind;
      req_vertex_count <= vc;
      req_slot_index <= idx;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      sb.note_request(kind, vc, idx);
   endtask

   task automatic alloc_slot(input logic [VC_W-1:0] vc);
      send_request(REQ_ALLOC, vc, SLOT_W'($urandom));
   endtask

   task automatic free_slot(input logic [SLOT_W-1:0] idx);
      send_request(REQ_FREE, VC_W'($urandom), idx);
   endtask

   task automatic idle_gap(input int pct);
      while ($urandom_range(0, 99) < pct) begin
         @(negedge clock);
         start <= 1'b0;
         req_type <= 1'($urandom);
         req_vertex_count <= VC_W'($urandom);
         req_slot_index <= SLOT_W'($urandom);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic random_request();
      int                r;
      int                live [$];
      logic [SLOT_W-1:0] idx;
      r = $urandom_range(0, 99);
      for (int i = 0; i < sb.slots_created; i++) begin
         if (!sb.on_free_list[i]) live = {live, i};
      end
      if (r < 35 && live.size() > 0) begin
         free_slot(SLOT_W'(live[$urandom_range(0, live.size() - 1)]));
      end else if (r < 65 && sb.free_list.size() > 0) begin
         idx = sb.free_list[$urandom_range(0, sb.free_list.size() - 1)];
         alloc_slot(sb.size_of[idx]);
      end else if (r < 80) begin
         // few distinct sizes so the free list holds several slots of one size
         alloc_slot(VC_W'($urandom_range(0, 3)) | ($urandom_range(0, 1) ? 10'h3FC : 10'h000));
      end else if (r < 90) begin
         alloc_slot(VC_W'($urandom));
      end else if (sb.free_list.size() > 0 && $urandom_range(0, 1)) begin
         free_slot(sb.free_list[$urandom_range(0, sb.free_list.size() - 1)]);
      end else begin
         free_slot(SLOT_W'($urandom));
      end
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      start = 1'b0;
      req_type = REQ_ALLOC;
      req_vertex_count = '0;
      req_slot_index = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      free_slot(8'd0);
      alloc_slot(10'd0);
      alloc_slot(10'd1023);
      alloc_slot(10'd5);
      alloc_slot(10'd5);
      free_slot(8'd2);
      free_slot(8'd2);
      free_slot(8'd3);
      free_slot(8'd255);
      alloc_slot(10'd5);
      alloc_slot(10'd5);
      free_slot(8'd0);
      free_slot(8'd1);
      free_slot(8'd2);
      alloc_slot(10'd1023);
      alloc_slot(10'd0);
      alloc_slot(10'd5);
      alloc_slot(10'd7);
      free_slot(8'd4);
      alloc_slot(10'd6);

      foreach (idle_pct[p]) begin
         drain();
         repeat (ITEMS_PER_LOOP) begin
            random_request();
            idle_gap(idle_pct[p]);
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      sb.close_out();
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/smsa_pkg.sv
rtl/smsa_cell.sv
rtl/size_matched_slot_allocator.sv
sim/size_matched_slot_allocator_tb.sv
